// ----- rtl/lifo_stack_with_peek_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the LIFO stack core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PEEK_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_PEEK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define LSWP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define LSWP_NEVER(lbl, clk, rst, cond, msg) \
   `LSWP_ASSERT(lbl, clk, rst, !(cond), msg)

`else

`define LSWP_ASSERT(lbl, clk, rst, prop, msg)
`define LSWP_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- rtl/lswp_pkg.sv -----
// ----------------------------------------------------------------------------
// LIFO stack package
// Opcodes, status codes and field widths shared by the stack core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lswp_pkg;

   // field widths fixed by the interface
   localparam int OPCODE_WIDTH = 2;
   localparam int VALUE_WIDTH  = 32;
   localparam int PEEK_WIDTH   = 6;
   localparam int COUNT_WIDTH  = 7;
   localparam int STATUS_WIDTH = 2;

   typedef logic [OPCODE_WIDTH-1:0] opcode_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;

   // operations
   localparam opcode_type OP_PUSH  = 2'd0;
   localparam opcode_type OP_POP   = 2'd1;
   localparam opcode_type OP_PEEK  = 2'd2;
   localparam opcode_type OP_CLEAR = 2'd3;

   // result status
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;
   localparam status_type STAT_RANGE = 2'd3;

   // capacity after reset
   localparam count_type CAPACITY_RESET = 7'd64;

endpackage

`default_nettype wire

// ----- rtl/lifo_stack_with_peek_core.sv -----
// ----------------------------------------------------------------------------
// LIFO stack with peek
// Bounded stack of words held in a RAM, with push, pop, peek and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer: the opcode in req_tuser, the
//   push word and the peek depth in req_tdata. Every request returns one
//   response on rsp_*: the status in rsp_tuser, and the peeked word, the
//   count after the operation and the empty and full flags in rsp_tdata.
//   csr_we writes the capacity (0 acts as 1, above DEPTH acts as DEPTH);
//   write it only while no request is outstanding.
// Sequencing:
//   A request is taken in S_IDLE, and a peek starts the registered read of
//   the entry RAM; the sequencer then waits in S_READ until the response
//   register is free and loads it; no new request is taken before S_IDLE.
// Reset:
//   Synchronous reset empties the stack and sets the capacity to 64. The
//   RAM itself is not cleared; entries below the count are always written.
// Stall:
//   The response register holds while rsp_tready is low; a following request
//   is taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lifo_stack_with_peek_core_assert.svh"

module lifo_stack_with_peek_core
   import lswp_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // push_value[31:0], peek_depth[37:32], zero pad
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // read_value[31:0], count[38:32],
                                         // is_empty[39], is_full[40], zero pad
   output      logic [1:0]  rsp_tuser,   // status[1:0]
   // configuration
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata    // capacity
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW = (AW > COUNT_WIDTH) ? AW : COUNT_WIDTH;
   localparam int RW = (WORD_WIDTH < VALUE_WIDTH) ? WORD_WIDTH : VALUE_WIDTH;
   localparam count_type CAP_MAX = (DEPTH > 127) ? 7'd127 : COUNT_WIDTH'(DEPTH);

   // sequencer states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                  state_ff, state_in;
   count_type             count_ff, count_in;
   count_type             capacity_ff;
   count_type             eff_cap;
   status_type            pend_status_ff, pend_status_in;
   logic                  pend_peek_ff, pend_peek_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   status_type            rsp_status_ff;
   count_type             rsp_count_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_full_ff;

   logic                  req_xfer;
   logic                  rsp_free;
   logic                  rsp_load;
   opcode_type            op;
   logic [VALUE_WIDTH-1:0] push_word;
   logic [PEEK_WIDTH-1:0] peek_depth;
   logic [IW-1:0]         count_ext;
   logic [IW-1:0]         peek_idx;

   logic                  mem_we;
   logic                  mem_re;
   logic [WORD_WIDTH-1:0] mem_rdata;
   logic [VALUE_WIDTH-1:0] rd_word;

   // request fields
   assign op         = req_tuser;
   assign push_word  = req_tdata[31:0];
   assign peek_depth = req_tdata[37:32];

   // capacity clamped to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = COUNT_WIDTH'(1);
      end else if (capacity_ff > CAP_MAX) begin
         eff_cap = CAP_MAX;
      end else begin
         eff_cap = capacity_ff;
      end
   end

   // handshake
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == S_READ) && rsp_free;

   // entry addresses: push writes at count, peek reads count-1-depth
   assign count_ext = IW'(count_ff);
   assign peek_idx  = count_ext - IW'(1) - IW'(peek_depth);

   // operation decode at the request transfer
   always_comb begin
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_peek_in   = pend_peek_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      if (req_xfer) begin
         pend_status_in = STAT_OK;
         pend_peek_in   = 1'b0;
         case (op)
            OP_PUSH: begin
               if (count_ff >= eff_cap) begin
                  pend_status_in = STAT_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  pend_status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
            OP_PEEK: begin
               if (count_ff == '0) begin
                  pend_status_in = STAT_EMPTY;
               end else if (COUNT_WIDTH'(peek_depth) >= count_ff) begin
                  pend_status_in = STAT_RANGE;
               end else begin
                  mem_re       = 1'b1;
                  pend_peek_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   // pending result of the operation in flight
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_peek_ff   <= pend_peek_in;
   end

   // entry store
   lswp_store #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ext[AW-1:0]),
      .wr_data (WORD_WIDTH'(push_word)),
      .rd_en   (mem_re),
      .rd_addr (peek_idx[AW-1:0]),
      .rd_data (mem_rdata)
   );

   // stored word back to the 32-bit field, zero filled
   assign rd_word = VALUE_WIDTH'(mem_rdata[RW-1:0]);

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= pend_peek_ff ? rd_word : '0;
         rsp_status_ff <= pend_status_ff;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_full_ff   <= (count_ff >= eff_cap);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_full_ff, rsp_empty_ff, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // checks
   `LSWP_NEVER(a_count_bound, clock, reset, count_ff > CAP_MAX,
      "entry count above the store depth")
   `LSWP_NEVER(a_push_room, clock, reset, mem_we && (count_ff >= eff_cap),
      "entry written while the stack is full")
   `LSWP_ASSERT(a_rsp_from_read, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_READ),
      "response raised without an operation in flight")
   `LSWP_ASSERT(a_peek_issued, clock, reset,
      (state_ff == S_READ) && pend_peek_ff |-> $past(mem_re) || $past(state_ff == S_READ),
      "peek result without a store read")

endmodule

`default_nettype wire

// ----- rtl/lswp_store.sv -----
// ----------------------------------------------------------------------------
// LIFO stack entry store
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lswp_store #(
   parameter  int DEPTH      = 64,
   parameter  int WORD_WIDTH = 32,
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [WORD_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output      logic [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- verif/tb_lifo_stack_with_peek_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LIFO stack with peek
// Drives push, pop, peek and clear transfers over several capacity settings
// and idle patterns, predicts every response from a shadow copy of the stack
// and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_peek_core;
   import lswp_pkg::*;

   localparam int DEPTH      = 64;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_MAX  = 5000;
   localparam int PRINT_MAX  = 50;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] value;
      logic [5:0]  depth;
   } stack_op_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      count_type   count;
      logic        empty;
      logic        full;
   } stack_reply_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [6:0]  csr_wdata  = CAPACITY_RESET;

   lifo_stack_with_peek_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // stimulus backlog and predicted responses
   stack_op_type    op_backlog[$];
   stack_reply_type pending_replies[$];

   // shadow of the stack
   logic [31:0] shadow_entries [DEPTH];
   int          shadow_count;
   logic [6:0]  shadow_capacity;

   // idle control
   int   sender_idle_pct = 0;
   int   recv_stall_pct  = 0;
   logic hold_arm        = 1'b0;
   logic hold_used       = 1'b0;
   int   hold_left       = 0;

   // bookkeeping
   logic req_taken = 1'b0;
   int   mismatch_count = 0;
   int   reply_index = 0;
   int   queued_total = 0;
   int   op_tally [4];
   int   stat_tally [4];
   int   capacity_writes = 0;

   stack_op_type    drv_item;
   logic            drv_valid;
   stack_op_type    seen_op;
   stack_reply_type want;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // one line per mismatch, printing capped
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp);
      mismatch_count++;
      if (mismatch_count <= PRINT_MAX)
         $display("[%0t] mismatch, reply %0d, %s: got %h expected %h",
                  $time, reply_index, what, got, exp);
   endtask

   // advance the shadow stack by one operation and return its response
   function automatic stack_reply_type apply_stack_op(input stack_op_type op);
      stack_reply_type r;
      int              cap;
      r = '0;
      r.status = STAT_OK;
      cap = int'(shadow_capacity);
      if (cap == 0) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      case (op.opcode)
         OP_PUSH: begin
            if (shadow_count >= cap) begin
               r.status = STAT_FULL;
            end else begin
               shadow_entries[shadow_count] = op.value;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else shadow_count--;
         end
         OP_PEEK: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else if (int'(op.depth) >= shadow_count) r.status = STAT_RANGE;
            else r.value = shadow_entries[shadow_count - 1 - int'(op.depth)];
         end
         default: shadow_count = 0;
      endcase
      r.count = count_type'(shadow_count);
      r.empty = (shadow_count == 0);
      r.full  = (shadow_count >= cap);
      return r;
   endfunction

   // driver: new transfer offered at the falling edge
   always @(negedge clock) begin
      drv_valid = req_tvalid;
      if (reset) begin
         drv_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (op_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            drv_item = op_backlog.pop_front();
            drv_valid = 1'b1;
            req_tdata <= {2'b00, drv_item.depth, drv_item.value};
            req_tuser <= drv_item.opcode;
         end else begin
            drv_valid = 1'b0;
         end
      end
      req_tvalid <= drv_valid;
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_used) begin
         hold_left <= HOLD_LEN;
         hold_used <= 1'b1;
      end
   end

   // receiver ready
   always @(negedge clock) begin
      rsp_tready <= !reset && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      if (reset) begin
         shadow_count = 0;
         shadow_capacity = CAPACITY_RESET;
      end else begin
         if (csr_we) shadow_capacity = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with none expected", rsp_tdata[31:0], '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("read_value", rsp_tdata[31:0], want.value);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[38:32] !== want.count)
                  report_mismatch("count", 32'(rsp_tdata[38:32]), 32'(want.count));
               if (rsp_tdata[39] !== want.empty)
                  report_mismatch("is_empty", 32'(rsp_tdata[39]), 32'(want.empty));
               if (rsp_tdata[40] !== want.full)
                  report_mismatch("is_full", 32'(rsp_tdata[40]), 32'(want.full));
            end
            reply_index++;
         end
         if (req_tvalid && req_tready) begin
            seen_op.opcode = req_tuser;
            seen_op.value  = req_tdata[31:0];
            seen_op.depth  = req_tdata[37:32];
            want = apply_stack_op(seen_op);
            pending_replies.push_back(want);
            op_tally[seen_op.opcode]++;
            stat_tally[want.status]++;
         end
      end
   end

   task automatic queue_op(input opcode_type opc, input logic [31:0] val,
                           input logic [5:0] dep);
      stack_op_type item;
      item.opcode = opc;
      item.value  = val;
      item.depth  = dep;
      op_backlog.push_back(item);
      queued_total++;
   endtask

   // random operations; push_pct sets how hard the stack is driven toward full
   task automatic queue_random(input int n, input int push_pct);
      opcode_type  opc;
      logic [31:0] val;
      logic [5:0]  dep;
      int          pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < push_pct) begin
            opc = OP_PUSH;
         end else begin
            pick = $urandom_range(99);
            if (pick < 40) opc = OP_POP;
            else if (pick < 96) opc = OP_PEEK;
            else opc = OP_CLEAR;
         end
         val = $urandom;
         case ($urandom_range(19))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'h0000_0000;
            3: val = 32'hFFFF_FFFF;
            default: ;
         endcase
         dep = ($urandom_range(99) < 60) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
         queue_op(opc, val, dep);
      end
   endtask

   // wait until everything queued has been answered
   task automatic wait_idle();
      @(negedge clock);
      while (reply_index < queued_total)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // capacity is only written while idle
   task automatic write_capacity(input logic [6:0] cap);
      wait_idle();
      csr_wdata <= cap;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      capacity_writes++;
   endtask

   task automatic set_idle(input int sender_pct, input int recv_pct);
      sender_idle_pct = sender_pct;
      recv_stall_pct  = recv_pct;
   endtask

   initial begin : stimulus
      int waited;
      for (int i = 0; i < 4; i++) begin
         op_tally[i] = 0;
         stat_tally[i] = 0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: empty stack, extreme words, peek depths
      set_idle(0, 0);
      write_capacity(7'd64);
      queue_op(OP_POP,   32'h0, 6'd0);
      queue_op(OP_PEEK,  32'h0, 6'd63);   // empty wins over depth
      queue_op(OP_CLEAR, 32'h0, 6'd0);
      queue_op(OP_PUSH,  32'h8000_0000, 6'd0);
      queue_op(OP_PUSH,  32'h7FFF_FFFF, 6'd0);
      queue_op(OP_PUSH,  32'h0000_0000, 6'd0);
      queue_op(OP_PUSH,  32'hFFFF_FFFF, 6'd0);
      queue_op(OP_PEEK,  32'h0, 6'd0);
      queue_op(OP_PEEK,  32'h0, 6'd3);
      queue_op(OP_PEEK,  32'h0, 6'd4);    // one past the held entries
      queue_op(OP_PEEK,  32'h0, 6'd63);
      queue_op(OP_POP,   32'h0, 6'd0);
      queue_op(OP_PEEK,  32'h0, 6'd0);

      // capacity dropped below the held count
      write_capacity(7'd2);
      queue_op(OP_PUSH,  32'h1111_2222, 6'd0);
      queue_op(OP_PEEK,  32'h0, 6'd2);
      queue_op(OP_POP,   32'h0, 6'd0);
      queue_op(OP_POP,   32'h0, 6'd0);
      queue_op(OP_PUSH,  32'hAAAA_5555, 6'd0);
      queue_op(OP_CLEAR, 32'h0, 6'd0);

      // capacity zero behaves as one
      write_capacity(7'd0);
      queue_op(OP_PUSH,  32'h0000_1234, 6'd0);
      queue_op(OP_PUSH,  32'h0000_5678, 6'd0);
      queue_op(OP_POP,   32'h0, 6'd0);
      queue_op(OP_POP,   32'h0, 6'd0);

      // random phases
      write_capacity(7'd64);
      queue_random(150, 85);
      write_capacity(7'd1);
      set_idle(73, 0);
      queue_random(100, 50);
      write_capacity(7'd0);
      set_idle(0, 73);
      queue_random(100, 50);
      write_capacity(7'd127);
      set_idle(6, 6);
      queue_random(150, 85);

      // long receiver hold-off while the sender keeps offering
      write_capacity(7'($urandom_range(1, 64)));
      set_idle(0, 0);
      hold_arm = 1'b1;
      queue_random(150, 70);

      write_capacity(7'd100);
      set_idle(73, 0);
      queue_random(100, 80);
      write_capacity(7'($urandom_range(1, 64)));
      set_idle(0, 73);
      queue_random(100, 60);
      write_capacity(7'd64);
      set_idle(6, 6);
      queue_random(100, 75);

      // drain, bounded
      waited = 0;
      while (reply_index < queued_total && waited < DRAIN_MAX) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (reply_index < queued_total)
         report_mismatch("responses never arrived", 32'(queued_total - reply_index), '0);

      $display("covered %0d transfers (push %0d, pop %0d, peek %0d, clear %0d), %0d capacity writes",
               reply_index, op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_PEEK],
               op_tally[OP_CLEAR], capacity_writes);
      $display("statuses: ok %0d, empty %0d, full %0d, out of range %0d; %0d mismatches",
               stat_tally[STAT_OK], stat_tally[STAT_EMPTY], stat_tally[STAT_FULL],
               stat_tally[STAT_RANGE], mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- lifo_stack_with_peek_core.f -----
+incdir+rtl
rtl/lswp_pkg.sv
rtl/lswp_store.sv
rtl/lifo_stack_with_peek_core.sv
verif/tb_lifo_stack_with_peek_core.sv
